// ===== rtl/core/ttw_pkg.sv =====
package ttw_pkg;

	// Screen geometry
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;

	localparam int ROW_W  = $clog2(SCREEN_ROWS);
	localparam int COL_W  = $clog2(SCREEN_COLS);
	localparam int ADDR_W = $clog2(CELL_COUNT);

	// Port widths
	localparam int CELL_W    = 16;
	localparam int CHAR_W    = 8;
	localparam int IN_ROW_W  = 5;
	localparam int IN_COL_W  = 7;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_COL_W = 7;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, BLANK_CODE};

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [1:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_READ,
		OP_READ_OOR
	} op_kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_RUN,
		BK_FILL
	} back_state_t;

	// Work handed from the front to the back
	typedef struct packed {
		logic                 wr_en;
		logic                 rd_en;
		addr_t                addr;
		cell_t                wr_cell;
		logic                 fill;
		row_t                 fill_row;
		logic [CHAR_W-1:0]    attr;
		logic [OUT_ROW_W-1:0] cursor_row;
		logic [OUT_COL_W-1:0] cursor_col;
		logic                 scrolled;
	} cmd_t;

	typedef struct packed {
		cell_t                entry;
		logic [OUT_ROW_W-1:0] cursor_row;
		logic [OUT_COL_W-1:0] cursor_col;
		logic                 scrolled;
	} res_t;

	function automatic addr_t cell_addr(input row_t row, input col_t col);
		return ADDR_W'(32'(row) * 32'(SCREEN_COLS) + 32'(col));
	endfunction

	// Map a screen row to a row of the store, which rotates by one row per scroll
	function automatic row_t wrap_row(input row_t row, input row_t top);
		logic [ROW_W:0] sum;
		sum = {1'b0, row} + {1'b0, top};
		if (sum >= (ROW_W + 1)'(SCREEN_ROWS)) begin
			sum = sum - (ROW_W + 1)'(SCREEN_ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

endpackage

// ===== rtl/core/ttw_ram.sv =====
module ttw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/ttw_cmd_queue.sv =====
module ttw_cmd_queue import ttw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic q_empty
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_cmd  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== rtl/core/ttw_front.sv =====
module ttw_front import ttw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 stall,
	output logic                 full,
	input  logic                 command,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [CHAR_W-1:0]    attribute,
	input  logic [IN_ROW_W-1:0]  read_row,
	input  logic [IN_COL_W-1:0]  read_col,
	output logic                 cmd_valid,
	output cmd_t                 cmd
);

	row_t     row_q;
	col_t     col_q;
	row_t     top_q;
	row_t     row_d;
	col_t     col_d;
	row_t     top_d;
	op_kind_t kind;
	logic     rd_in_range;
	logic     adv_row;
	logic     scroll;

	assign full      = stall;
	assign cmd_valid = push && !stall;

	assign rd_in_range = (32'(read_row) < 32'(SCREEN_ROWS))
		&& (32'(read_col) < 32'(SCREEN_COLS));

	always_comb begin
		if (command) begin
			kind = rd_in_range ? OP_READ : OP_READ_OOR;
		end else if (char_code == NEWLINE_CODE) begin
			kind = OP_NEWLINE;
		end else begin
			kind = OP_PUT;
		end
	end

	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		top_d   = top_q;
		adv_row = 1'b0;
		scroll  = 1'b0;
		cmd     = '0;

		case (kind)
			OP_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.addr    = cell_addr(wrap_row(row_q, top_q), col_q);
				cmd.wr_cell = {attribute, char_code};
				adv_row     = (col_q == COL_W'(SCREEN_COLS - 1));
				col_d       = adv_row ? '0 : col_q + 1'b1;
			end
			OP_NEWLINE: begin
				adv_row = 1'b1;
				col_d   = '0;
			end
			OP_READ: begin
				cmd.rd_en = 1'b1;
				cmd.addr  = cell_addr(wrap_row(ROW_W'(read_row), top_q), COL_W'(read_col));
			end
			default: begin
			end
		endcase

		// Past the last row: rotate the store by one row, cursor stays on the last row
		if (adv_row) begin
			if (row_q == ROW_W'(SCREEN_ROWS - 1)) begin
				scroll = 1'b1;
				top_d  = (top_q == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top_q + 1'b1;
			end else begin
				row_d = row_q + 1'b1;
			end
		end

		cmd.fill       = scroll;
		cmd.fill_row   = top_q;
		cmd.attr       = attribute;
		cmd.scrolled   = scroll;
		cmd.cursor_row = OUT_ROW_W'(row_d);
		cmd.cursor_col = OUT_COL_W'(col_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			top_q <= '0;
		end else if (cmd_valid) begin
			row_q <= row_d;
			col_q <= col_d;
			top_q <= top_d;
		end
	end

endmodule

// ===== rtl/core/ttw_back.sv =====
module ttw_back import ttw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_empty,
	input  cmd_t                 cmd,
	output logic                 cmd_pop,
	output logic                 clearing,
	output logic                 empty,
	input  logic                 pop,
	output logic [CELL_W-1:0]    cell_entry,
	output logic [OUT_ROW_W-1:0] cursor_row,
	output logic [OUT_COL_W-1:0] cursor_col,
	output logic                 scrolled
);

	back_state_t state_q;
	back_state_t state_d;

	addr_t sweep_q;
	col_t  fill_col_q;
	row_t  fill_row_q;
	cell_t fill_cell_q;

	logic                 valid_s1;
	logic                 rd_s1;
	logic [OUT_ROW_W-1:0] row_s1;
	logic [OUT_COL_W-1:0] col_s1;
	logic                 scr_s1;

	res_t                  res_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] res_wptr_q;
	logic [RESQ_PTR_W-1:0] res_rptr_q;
	logic [RESQ_CNT_W-1:0] res_cnt_q;
	logic [RESQ_CNT_W:0]   res_pending;
	logic                  res_pop;
	res_t                  res_in;
	res_t                  res_head;

	logic  issue;
	logic  sweep_last;
	logic  fill_last;
	logic  ram_we;
	addr_t ram_waddr;
	cell_t ram_wdata;
	logic  ram_re;
	cell_t ram_rdata;

	// Count the result in flight so the result queue never overflows
	assign res_pending = {1'b0, res_cnt_q} + (RESQ_CNT_W + 1)'(valid_s1);
	assign issue       = (state_q == BK_RUN) && !cmd_empty
		&& (res_pending < (RESQ_CNT_W + 1)'(RESQ_DEPTH));
	assign sweep_last  = (sweep_q == ADDR_W'(CELL_COUNT - 1));
	assign fill_last   = (fill_col_q == COL_W'(SCREEN_COLS - 1));
	assign clearing    = (state_q == BK_CLEAR);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (sweep_last) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (issue && cmd.fill) begin
					state_d = BK_FILL;
				end
			end
			BK_FILL: begin
				if (fill_last) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cmd.addr;
		ram_wdata = cmd.wr_cell;
		ram_re    = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = RESET_CELL;
			end
			BK_RUN: begin
				cmd_pop = issue;
				ram_we  = issue && cmd.wr_en;
				ram_re  = issue && cmd.rd_en;
			end
			BK_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(fill_row_q, fill_col_q);
				ram_wdata = fill_cell_q;
			end
			default: begin
			end
		endcase
	end

	ttw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cmd.addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_CLEAR;
			sweep_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (state_q == BK_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1       <= cmd.rd_en;
			row_s1      <= cmd.cursor_row;
			col_s1      <= cmd.cursor_col;
			scr_s1      <= cmd.scrolled;
			fill_row_q  <= cmd.fill_row;
			fill_cell_q <= {cmd.attr, BLANK_CODE};
			fill_col_q  <= '0;
		end else if (state_q == BK_FILL) begin
			fill_col_q <= fill_col_q + 1'b1;
		end
	end

	always_comb begin
		res_in.entry      = rd_s1 ? ram_rdata : '0;
		res_in.cursor_row = row_s1;
		res_in.cursor_col = col_s1;
		res_in.scrolled   = scr_s1;
	end

	assign empty    = (res_cnt_q == '0);
	assign res_pop  = pop && !empty;
	assign res_head = res_q[res_rptr_q];

	assign cell_entry = res_head.entry;
	assign cursor_row = res_head.cursor_row;
	assign cursor_col = res_head.cursor_col;
	assign scrolled   = res_head.scrolled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wptr_q <= '0;
			res_rptr_q <= '0;
			res_cnt_q  <= '0;
		end else begin
			if (valid_s1) begin
				res_wptr_q <= (res_wptr_q == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0
					: res_wptr_q + 1'b1;
			end
			if (res_pop) begin
				res_rptr_q <= (res_rptr_q == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0
					: res_rptr_q + 1'b1;
			end
			if (valid_s1 && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_pop && !valid_s1) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q[res_wptr_q] <= res_in;
		end
	end

endmodule

// ===== rtl/core/text_terminal_writer.sv =====
// A word passes through the command queue, the read stage and the result queue to the ports.
// A new word can be issued while another is in the read stage, but the word
// in the read stage counts against the two-entry result queue.
// A put or newline that scrolls holds the back end while the freed row is filled with blanks;
// the store rotates by a row pointer, nothing is copied.
// Reset: asynchronous, active low; afterwards a clearing pass writes all 2000 cells, one per
// cycle, with full held high until the pass ends.
module text_terminal_writer import ttw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 command,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [CHAR_W-1:0]    attribute,
	input  logic [IN_ROW_W-1:0]  read_row,
	input  logic [IN_COL_W-1:0]  read_col,
	output logic                 empty,
	input  logic                 pop,
	output logic [CELL_W-1:0]    cell_entry,
	output logic [OUT_ROW_W-1:0] cursor_row,
	output logic [OUT_COL_W-1:0] cursor_col,
	output logic                 scrolled
);

	logic front_valid;
	cmd_t front_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_cmd;
	logic clearing;

	ttw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.stall    (q_full || clearing),
		.full     (full),
		.command  (command),
		.char_code(char_code),
		.attribute(attribute),
		.read_row (read_row),
		.read_col (read_col),
		.cmd_valid(front_valid),
		.cmd      (front_cmd)
	);

	ttw_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_valid),
		.wr_cmd (front_cmd),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_cmd),
		.q_empty(q_empty)
	);

	ttw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_empty),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.cell_entry(cell_entry),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.scrolled  (scrolled)
	);

endmodule

// ===== rtl/core/ttw_checker.sv =====
module ttw_checker import ttw_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [CELL_W-1:0]    cell_entry,
	input logic [OUT_ROW_W-1:0] cursor_row,
	input logic [OUT_COL_W-1:0] cursor_col,
	input logic                 scrolled
);

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(cursor_row) < 32'(SCREEN_ROWS)) && (32'(cursor_col) < 32'(SCREEN_COLS)))
		else $error("cursor outside the screen");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && scrolled |->
			(cursor_row == OUT_ROW_W'(SCREEN_ROWS - 1)) && (cursor_col == '0))
		else $error("scroll did not leave the cursor at the start of the last row");

	a_scroll_is_put: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && scrolled |-> (cell_entry == '0))
		else $error("scrolled word carries cell data");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(cell_entry) && $stable(cursor_row)
			&& $stable(cursor_col) && $stable(scrolled))
		else $error("waiting result changed before it was taken");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (.*);

// ===== bench/text_terminal_writer_tb.sv =====
`timescale 1ns / 100ps

module text_terminal_writer_tb;
	import ttw_pkg::*;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;
	localparam int   CYCLE_LIMIT = 1500000;
	localparam int   DRAIN_CYCLES = 200;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 command = CMD_PUT;
	logic [CHAR_W-1:0]    char_code = '0;
	logic [CHAR_W-1:0]    attribute = '0;
	logic [IN_ROW_W-1:0]  read_row = '0;
	logic [IN_COL_W-1:0]  read_col = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [CELL_W-1:0]    cell_entry;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [OUT_COL_W-1:0] cursor_col;
	logic                 scrolled;

	// Shadow copy of the screen and cursor, advanced at each accepted word
	cell_t screen_shadow [CELL_COUNT];
	int    cur_row;
	int    cur_col;
	res_t  pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int put_count = 0;
	int newline_count = 0;
	int read_count = 0;
	int offscreen_count = 0;
	int scroll_count = 0;
	int checked_count = 0;

	text_terminal_writer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.char_code  (char_code),
		.attribute  (attribute),
		.read_row   (read_row),
		.read_col   (read_col),
		.empty      (empty),
		.pop        (pop),
		.cell_entry (cell_entry),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
			$display("text_terminal_writer regression: fail");
			$finish;
		end
	end

	function automatic res_t step_screen(input logic cmd, input logic [CHAR_W-1:0] ch,
			input logic [CHAR_W-1:0] attr, input logic [IN_ROW_W-1:0] rrow,
			input logic [IN_COL_W-1:0] rcol);
		res_t r;
		r = '0;
		if (cmd == CMD_READ) begin
			read_count++;
			if (int'(rrow) < SCREEN_ROWS && int'(rcol) < SCREEN_COLS) begin
				r.entry = screen_shadow[int'(rrow) * SCREEN_COLS + int'(rcol)];
			end else begin
				offscreen_count++;
			end
		end else begin
			if (ch == NEWLINE_CODE) begin
				newline_count++;
				cur_col = 0;
				cur_row++;
			end else begin
				put_count++;
				screen_shadow[cur_row * SCREEN_COLS + cur_col] = {attr, ch};
				cur_col++;
			end
			if (cur_col >= SCREEN_COLS) begin
				cur_col = 0;
				cur_row++;
			end
			if (cur_row >= SCREEN_ROWS) begin
				// shift everything up one row, blank the bottom row in this attribute
				for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++) begin
					screen_shadow[i] = screen_shadow[i + SCREEN_COLS];
				end
				for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++) begin
					screen_shadow[i] = {attr, BLANK_CODE};
				end
				cur_col = 0;
				cur_row = SCREEN_ROWS - 1;
				r.scrolled = 1'b1;
				scroll_count++;
			end
		end
		r.cursor_row = cur_row[OUT_ROW_W-1:0];
		r.cursor_col = cur_col[OUT_COL_W-1:0];
		return r;
	endfunction

	task automatic send_word(input logic cmd, input logic [CHAR_W-1:0] ch,
			input logic [CHAR_W-1:0] attr, input logic [IN_ROW_W-1:0] rrow,
			input logic [IN_COL_W-1:0] rcol);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		command   <= cmd;
		char_code <= ch;
		attribute <= attr;
		read_row  <= rrow;
		read_col  <= rcol;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_results.push_back(step_screen(cmd, ch, attr, rrow, rcol));
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr);
		send_word(CMD_PUT, ch, attr, IN_ROW_W'($urandom), IN_COL_W'($urandom));
	endtask

	task automatic read_cell(input int row, input int col);
		send_word(CMD_READ, CHAR_W'($urandom), CHAR_W'($urandom), IN_ROW_W'(row),
			IN_COL_W'(col));
	endtask

	// Receiver: random pops, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word, actual cell %h row %0d col %0d scrolled %0b",
					$time, cell_entry, cursor_row, cursor_col, scrolled);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("cell_entry", want.entry, cell_entry);
				check_field("cursor_row", want.cursor_row, cursor_row);
				check_field("cursor_col", want.cursor_col, cursor_col);
				check_field("scrolled", want.scrolled, scrolled);
				checked_count++;
			end
		end
	end

	task automatic test_reset_screen();
		read_cell(0, 0);
		read_cell(SCREEN_ROWS - 1, SCREEN_COLS - 1);
		read_cell(SCREEN_ROWS, 0);
		read_cell(0, SCREEN_COLS);
		read_cell(31, 127);
	endtask

	task automatic test_put_and_read();
		put_char(8'h41, 8'h1E);
		put_char(8'hFF, 8'hFF);
		put_char(8'h00, 8'h00);
		put_char(8'h80, 8'h70);
		read_cell(0, 0);
		read_cell(0, 1);
		read_cell(0, 2);
		read_cell(0, 3);
	endtask

	task automatic test_newline();
		put_char(NEWLINE_CODE, 8'hA5);
		put_char(8'h7E, 8'h5A);
		read_cell(1, 0);
		read_cell(0, 4);
		put_char(NEWLINE_CODE, 8'h00);
	endtask

	task automatic test_wrap_and_scroll();
		// fill a row to force a wrap, then walk to the bottom row
		repeat (SCREEN_COLS) put_char(CHAR_W'($urandom_range(255, 11)), CHAR_W'($urandom));
		read_cell(cur_row - 1, SCREEN_COLS - 1);
		read_cell(cur_row, 0);
		while (cur_row < SCREEN_ROWS - 1) put_char(NEWLINE_CODE, CHAR_W'($urandom));
		repeat (SCREEN_COLS) put_char(CHAR_W'($urandom_range(255, 11)), 8'h3C);
		read_cell(SCREEN_ROWS - 1, 0);
		read_cell(SCREEN_ROWS - 2, SCREEN_COLS - 1);
		put_char(8'h62, 8'h4B);
		put_char(NEWLINE_CODE, 8'hC3);
		read_cell(SCREEN_ROWS - 1, 5);
		read_cell(SCREEN_ROWS - 2, 0);
		read_cell(0, 0);
	endtask

	task automatic test_fill_stall();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		// drop the word just taken so it is not offered again
		push <= 1'b0;
		@(negedge clk);
		hold_left = 400;
		@(posedge clk);
		repeat (40) begin
			if ($urandom_range(1)) put_char(CHAR_W'($urandom), CHAR_W'($urandom));
			else read_cell($urandom_range(SCREEN_ROWS - 1), $urandom_range(SCREEN_COLS - 1));
		end
		send_idle_pct = saved_idle;
	endtask

	task automatic test_random_traffic(input int count);
		int sent;
		int pick;
		int burst;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				// run of newlines to push the cursor toward a scroll
				burst = $urandom_range(30, 5);
				repeat (burst) put_char(NEWLINE_CODE, CHAR_W'($urandom));
				sent += burst;
			end else begin
				if (pick < 50) put_char(CHAR_W'($urandom), CHAR_W'($urandom));
				else if (pick < 58) put_char(NEWLINE_CODE, CHAR_W'($urandom));
				else if (pick < 70) read_cell(cur_row, $urandom_range(cur_col));
				else if (pick < 78) read_cell(SCREEN_ROWS - 1, $urandom_range(SCREEN_COLS - 1));
				else if (pick < 92) read_cell($urandom_range(SCREEN_ROWS - 1),
					$urandom_range(SCREEN_COLS - 1));
				else read_cell($urandom_range(31), $urandom_range(127));
				sent++;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = RESET_CELL;
		cur_row = 0;
		cur_col = 0;
		send_idle_pct = 28;
		recv_idle_pct = 70;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_screen();
		test_put_and_read();
		test_newline();
		test_wrap_and_scroll();
		test_fill_stall();
		test_random_traffic(600);

		send_idle_pct = 70;
		recv_idle_pct = 28;
		test_random_traffic(600);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(500);

		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d puts, %0d newlines, %0d reads (%0d off screen), %0d scrolls",
			put_count, newline_count, read_count, offscreen_count, scroll_count);
		$display("%0d words checked, %0d mismatches, %0d cycles", checked_count, errors, cycles);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("text_terminal_writer regression: pass");
		end else begin
			$display("text_terminal_writer regression: fail");
		end
		$finish;
	end

endmodule
